FILE: src/qph_pkg.sv
// shared types and constants of the quadratic probing hash table
package qph_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 31;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 6;
  localparam int OCC_W      = 7;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd6;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_LIVE    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic start;
    logic advance;
  } probe_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

endpackage

FILE: src/qph_ram.sv
// generic single write port ram with registered read
module qph_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/qph_probe.sv
// probe address generator: home plus q squared, stepped by odd increments
module qph_probe (
  input  logic                                clk,
  input  qph_pkg::probe_ctrl_t                ctrl,
  input  logic [qph_pkg::SLOT_W-1:0]          home,
  output logic [qph_pkg::SLOT_W-1:0]          cur_slot,
  output logic [qph_pkg::SLOT_W-1:0]          next_slot,
  output logic                                last
);

  logic [qph_pkg::SLOT_W-1:0] step;
  logic [qph_pkg::SLOT_W-1:0] q;

  // q squared advances by 2q+1, all modulo the table size
  assign next_slot = ctrl.start ? home : cur_slot + step;
  assign last      = (q == qph_pkg::SLOT_W'(qph_pkg::TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cur_slot <= home;
      step     <= qph_pkg::SLOT_W'(1);
      q        <= '0;
    end else if (ctrl.advance) begin
      cur_slot <= next_slot;
      step     <= step + qph_pkg::SLOT_W'(2);
      q        <= q + qph_pkg::SLOT_W'(1);
    end
  end

endmodule

FILE: src/quadratic_probe_hash_table.sv
// top level of the quadratic probing hash table
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+--------------------
//  in      | in_valid in_ready kind key       | input     | one operation
//  out     | out_valid out_ready status slot  | output    | one result
//          | occupancy                        |           |
//
// an item is taken in, probed slot by slot (1 to 64 probes) and then posts
// its result; full, empty and unused kinds skip probing. the probe loop is
// bound by the single read port of the slot ram, which returns one slot a
// cycle. reset clears the per slot valid bits and the live count; no
// clearing pass is needed. a result left waiting on out holds the block in
// its finishing step until the previous beat is taken.
module quadratic_probe_hash_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [qph_pkg::KIND_W-1:0]        kind,
  input  logic [qph_pkg::KEY_W-1:0]         key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [qph_pkg::STATUS_W-1:0]      status,
  output logic [qph_pkg::SLOT_OUT_W-1:0]    slot,
  output logic [qph_pkg::OCC_W-1:0]         occupancy
);

  qph_pkg::state_t      state, state_next;
  qph_pkg::probe_ctrl_t pctrl;

  // operation under way
  logic [qph_pkg::KIND_W-1:0]   op_kind;
  logic [qph_pkg::KEY_W-1:0]    op_key;
  logic [qph_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [qph_pkg::SLOT_W-1:0]   res_slot, res_slot_next;

  // table state
  logic [qph_pkg::TABLE_SIZE-1:0] valid_bits;
  logic [qph_pkg::COUNT_W-1:0]    live_count, live_count_next;

  // probe unit and ram
  logic [qph_pkg::SLOT_W-1:0] cur_slot, next_slot;
  logic                       probe_last;
  qph_pkg::entry_t            rd_entry, wr_entry;
  logic                       wr_en;

  logic accept, finish, slot_live, key_match;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == qph_pkg::S_IDLE);

  // a slot never written reads as empty
  assign slot_live = valid_bits[cur_slot] && (rd_entry.mark == qph_pkg::MARK_LIVE);
  assign key_match = (rd_entry.key == op_key);

  qph_probe u_probe (
    .clk       (clk),
    .ctrl      (pctrl),
    .home      (key[qph_pkg::SLOT_W-1:0]),
    .cur_slot  (cur_slot),
    .next_slot (next_slot),
    .last      (probe_last)
  );

  qph_ram #(
    .Width ($bits(qph_pkg::entry_t)),
    .Depth (qph_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (res_slot),
    .wdata (wr_entry),
    .raddr (next_slot),
    .rdata (rd_entry)
  );

  // sequencer: next state, probe control and pending result
  always_comb begin
    state_next      = state;
    pctrl.start     = 1'b0;
    pctrl.advance   = 1'b0;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    finish          = 1'b0;
    unique case (state)
      qph_pkg::S_IDLE: begin
        pctrl.start = 1'b1;
        if (accept) begin
          res_slot_next = '0;
          state_next    = qph_pkg::S_FINISH;
          priority if (kind == qph_pkg::KIND_INSERT) begin
            if (live_count >= qph_pkg::COUNT_W'(qph_pkg::TABLE_SIZE)) begin
              res_status_next = qph_pkg::STAT_FULL;
            end else begin
              state_next = qph_pkg::S_PROBE;
            end
          end else if (kind == qph_pkg::KIND_SEARCH) begin
            state_next = qph_pkg::S_PROBE;
          end else if (kind == qph_pkg::KIND_REMOVE) begin
            if (live_count == '0) begin
              res_status_next = qph_pkg::STAT_EMPTY;
            end else begin
              state_next = qph_pkg::S_PROBE;
            end
          end else begin
            res_status_next = qph_pkg::STAT_NOT_FOUND;
          end
        end
      end
      qph_pkg::S_PROBE: begin
        // ram data now belongs to cur_slot
        state_next = qph_pkg::S_FINISH;
        if (op_kind == qph_pkg::KIND_INSERT) begin
          priority if (!slot_live) begin
            res_status_next = qph_pkg::STAT_INSERTED;
            res_slot_next   = cur_slot;
          end else if (key_match) begin
            res_status_next = qph_pkg::STAT_DUPLICATE;
          end else if (probe_last) begin
            res_status_next = qph_pkg::STAT_FULL;
          end else begin
            state_next    = qph_pkg::S_PROBE;
            pctrl.advance = 1'b1;
          end
        end else begin
          priority if (slot_live && key_match) begin
            res_status_next = (op_kind == qph_pkg::KIND_REMOVE) ?
                              qph_pkg::STAT_REMOVED : qph_pkg::STAT_FOUND;
            res_slot_next   = cur_slot;
          end else if (probe_last) begin
            res_status_next = qph_pkg::STAT_NOT_FOUND;
          end else begin
            state_next    = qph_pkg::S_PROBE;
            pctrl.advance = 1'b1;
          end
        end
      end
      qph_pkg::S_FINISH: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = qph_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qph_pkg::S_IDLE;
      end
    endcase
  end

  // table update on the finishing cycle
  always_comb begin
    wr_en           = 1'b0;
    wr_entry.key    = op_key;
    wr_entry.mark   = qph_pkg::MARK_LIVE;
    live_count_next = live_count;
    if (finish && (res_status == qph_pkg::STAT_INSERTED)) begin
      wr_en           = 1'b1;
      live_count_next = live_count + qph_pkg::COUNT_W'(1);
    end else if (finish && (res_status == qph_pkg::STAT_REMOVED)) begin
      wr_en           = 1'b1;
      wr_entry.mark   = qph_pkg::MARK_DELETED;
      live_count_next = live_count - qph_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qph_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      live_count <= live_count_next;
      if (wr_en) begin
        valid_bits[res_slot] <= 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (accept) begin
      op_kind <= kind;
      op_key  <= key;
    end
    if (finish) begin
      status    <= res_status;
      slot      <= qph_pkg::SLOT_OUT_W'(res_slot);
      occupancy <= qph_pkg::OCC_W'(live_count_next);
    end
  end

endmodule
